[sv/ntc_thermistor_temperature_core_defines.svh]
// Assertion macros used by the thermistor conversion top level.
`ifndef NTC_THERMISTOR_TEMPERATURE_CORE_DEFINES_SVH
`define NTC_THERMISTOR_TEMPERATURE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NTC_ASSERT_IMPLY(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("ntc assertion failed");

// Next-cycle implication, disabled during reset.
`define NTC_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("ntc assertion failed");

`endif

[sv/ntc_pkg.sv]
// Types and constants of the thermistor temperature conversion pipeline.
package ntc_pkg;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OPEN  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    localparam logic [1:0] CFG_OPEN = 2'd0;
    localparam logic [1:0] CFG_MIN  = 2'd1;
    localparam logic [1:0] CFG_MAX  = 2'd2;

    localparam int LOG_FRAC = 30;
    localparam int MUL_W    = 36;
    localparam int HALF_W   = 18;
    localparam int NUM_W    = 48;
    localparam int DEN_W    = 35;
    localparam int Q_BITS   = 16;

    localparam logic signed [MUL_W-1:0] LN2_Q30      = 36'sd744261118;
    localparam logic signed [MUL_W-1:0] LN_RATIO_Q30 = -36'sd4303580;
    localparam logic signed [MUL_W-1:0] ST_A_Q40     = 36'sd3687780070;
    localparam logic signed [MUL_W-1:0] ST_B_Q40     = 36'sd329997332;
    localparam logic signed [MUL_W-1:0] ST_C_Q40     = 36'sd5591198;
    localparam logic signed [MUL_W-1:0] ST_D_Q40     = 36'sd240535;
    localparam logic [NUM_W-1:0]        NUM_BASE     = 48'd100 << 40;
    localparam logic signed [17:0]      KELVIN_CENTI = 18'sd27315;

    typedef struct packed {
        logic    valid;
        status_t status;
    } meta_t;

    typedef struct packed {
        logic [3:0]          e;
        logic [LOG_FRAC-1:0] frac;
        logic [LOG_FRAC:0]   m;
    } log_lane_t;

    typedef struct packed {
        logic [NUM_W-1:0]  r;
        logic [DEN_W-1:0]  den;
        logic [Q_BITS-1:0] q;
    } div_word_t;

endpackage

[sv/ntc_log_cell.sv]
// One squaring step of the log2 fraction for both lanes (ADC value and top minus value).
module ntc_log_cell
    import ntc_pkg::*;
#(
    parameter int BIT_POS = 29
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  meta_t     meta_in,
    input  log_lane_t v_in,
    input  log_lane_t d_in,
    output meta_t     meta_out,
    output log_lane_t v_out,
    output log_lane_t d_out
);

    function automatic log_lane_t sq_step(input log_lane_t l);
        logic [2*LOG_FRAC+1:0] sq;
        log_lane_t r;
        sq = (2*LOG_FRAC+2)'(l.m) * (2*LOG_FRAC+2)'(l.m);
        r = l;
        if (sq[2*LOG_FRAC+1]) begin
            r.m = sq[2*LOG_FRAC+1:LOG_FRAC+1];
            r.frac[BIT_POS] = 1'b1;
        end else begin
            r.m = sq[2*LOG_FRAC:LOG_FRAC];
        end
        return r;
    endfunction

    meta_t     meta_reg;
    log_lane_t v_reg, d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_reg.valid <= 1'b0;
        end else if (en) begin
            meta_reg <= meta_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg <= sq_step(v_in);
            d_reg <= sq_step(d_in);
        end
    end

    assign meta_out = meta_reg;
    assign v_out    = v_reg;
    assign d_out    = d_reg;

endmodule

[sv/ntc_mul_cell.sv]
// Two-stage multiply-accumulate cell: y = c + trunc(a * b / 2^30), b passed along.
module ntc_mul_cell
    import ntc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  meta_t                   meta_in,
    input  logic signed [MUL_W-1:0] a,
    input  logic signed [MUL_W-1:0] b,
    input  logic signed [MUL_W-1:0] c,
    output meta_t                   meta_out,
    output logic signed [MUL_W-1:0] y,
    output logic signed [MUL_W-1:0] b_out
);

    logic [MUL_W-1:0]          am, bm;
    meta_t                     meta1_reg, meta2_reg;
    logic                      neg_reg;
    logic [MUL_W+HALF_W-1:0]   plo_reg, phi_reg;
    logic signed [MUL_W-1:0]   b1_reg, c1_reg, b2_reg, y_reg;
    logic [2*MUL_W-1:0]        prod;
    logic [MUL_W-1:0]          mag;
    logic signed [MUL_W-1:0]   y_next;

    assign am = a[MUL_W-1] ? -a : a;
    assign bm = b[MUL_W-1] ? -b : b;

    always_comb begin
        prod   = {phi_reg, {HALF_W{1'b0}}} + (2*MUL_W)'(plo_reg);
        mag    = prod[MUL_W+LOG_FRAC-1:LOG_FRAC];
        y_next = c1_reg + (neg_reg ? -$signed(mag) : $signed(mag));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta1_reg.valid <= 1'b0;
            meta2_reg.valid <= 1'b0;
        end else if (en) begin
            meta1_reg <= meta_in;
            meta2_reg <= meta1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg <= a[MUL_W-1] ^ b[MUL_W-1];
            plo_reg <= am * bm[HALF_W-1:0];
            phi_reg <= am * bm[MUL_W-1:HALF_W];
            b1_reg  <= b;
            c1_reg  <= c;
            b2_reg  <= b1_reg;
            y_reg   <= y_next;
        end
    end

    assign meta_out = meta2_reg;
    assign y        = y_reg;
    assign b_out    = b2_reg;

endmodule

[sv/ntc_div_cell.sv]
// One restoring-division step producing quotient bit SHIFT.
module ntc_div_cell
    import ntc_pkg::*;
#(
    parameter int SHIFT = 15
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  meta_t     meta_in,
    input  div_word_t w_in,
    output meta_t     meta_out,
    output div_word_t w_out
);

    localparam int SUB_W = DEN_W + Q_BITS;

    logic [SUB_W-1:0] sub;
    div_word_t        w_next;
    meta_t            meta_reg;
    div_word_t        w_reg;

    always_comb begin
        sub    = SUB_W'(w_in.den) << SHIFT;
        w_next = w_in;
        if (SUB_W'(w_in.r) >= sub) begin
            w_next.r = w_in.r - sub[NUM_W-1:0];
            w_next.q[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_reg.valid <= 1'b0;
        end else if (en) begin
            meta_reg <= meta_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg <= w_next;
        end
    end

    assign meta_out = meta_reg;
    assign w_out    = w_reg;

endmodule

[sv/ntc_thermistor_temperature_core.sv]
// Top level of the NTC thermistor temperature conversion pipeline.
// One transaction is accepted every clock cycle while the result side is not stalled, and
// each gives one result through 58 register stages: an input register, 30 log2 squaring
// cells, a difference stage, four two-stage multiply cells (ln2 scaling and the
// Steinhart-Hart cubic), a divide setup stage, 16 restoring-division cells and the output
// register. A stall on the result side holds the whole pipeline. The open threshold is
// applied at the input register and the temperature limits at the output register, so
// write configuration registers only while no transaction is in flight.
`include "ntc_thermistor_temperature_core_defines.svh"
module ntc_thermistor_temperature_core
    import ntc_pkg::*;
#(
    parameter int ADC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_adc_value,
    input  logic [15:0]        s_adc_top,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [14:0] m_temperature_centi,
    output logic [1:0]         m_status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam logic [15:0] ADC_MASK = 16'((32'd1 << ADC_BITS) - 1);
    localparam int N_LOG = LOG_FRAC;

    logic [15:0]        open_thr_reg;
    logic signed [14:0] min_reg, max_reg;
    logic               en;

    logic [15:0] v, top, dv;
    status_t     pre_status;

    meta_t     meta0_reg;
    log_lane_t v0_reg, d0_reg;

    function automatic log_lane_t norm(input logic [15:0] n);
        logic [3:0]  e;
        logic [4:0]  sh;
        logic [45:0] wide;
        log_lane_t   r;
        e = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (n[i]) begin
                e = 4'(i);
            end
        end
        sh     = 5'(LOG_FRAC) - {1'b0, e};
        wide   = 46'(n) << sh;
        r.e    = e;
        r.frac = '0;
        r.m    = wide[LOG_FRAC:0];
        return r;
    endfunction

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_thr_reg <= 16'd29800;
            min_reg      <= -15'sd4000;
            max_reg      <= 15'sd10500;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_OPEN: open_thr_reg <= cfg_data;
                CFG_MIN:  min_reg      <= cfg_data[14:0];
                CFG_MAX:  max_reg      <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        v   = s_adc_value & ADC_MASK;
        top = s_adc_top & ADC_MASK;
        dv  = top - v;
        if (v > open_thr_reg) begin
            pre_status = ST_OPEN;
        end else if (v == 16'd0 || v >= top) begin
            pre_status = ST_RANGE;
        end else begin
            pre_status = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta0_reg.valid <= 1'b0;
        end else if (en) begin
            meta0_reg.valid <= s_valid;
            meta0_reg.status <= pre_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v0_reg <= norm(v);
            d0_reg <= norm(dv);
        end
    end

    meta_t     lmeta [N_LOG+1];
    log_lane_t lv [N_LOG+1];
    log_lane_t ld [N_LOG+1];

    assign lmeta[0] = meta0_reg;
    assign lv[0]    = v0_reg;
    assign ld[0]    = d0_reg;

    for (genvar j = 0; j < N_LOG; j++) begin : g_log
        ntc_log_cell #(.BIT_POS(N_LOG - 1 - j)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .meta_in  (lmeta[j]),
            .v_in     (lv[j]),
            .d_in     (ld[j]),
            .meta_out (lmeta[j+1]),
            .v_out    (lv[j+1]),
            .d_out    (ld[j+1])
        );
    end

    meta_t                   dmeta_reg;
    logic signed [MUL_W-1:0] diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dmeta_reg.valid <= 1'b0;
        end else if (en) begin
            dmeta_reg <= lmeta[N_LOG];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= $signed(MUL_W'({lv[N_LOG].e, lv[N_LOG].frac}))
                      - $signed(MUL_W'({ld[N_LOG].e, ld[N_LOG].frac}));
        end
    end

    meta_t                   mmeta [4];
    logic signed [MUL_W-1:0] my [4];
    logic signed [MUL_W-1:0] mk [3];

    ntc_mul_cell u_mul_ln2 (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .meta_in (dmeta_reg), .a (LN2_Q30), .b (diff_reg), .c (LN_RATIO_Q30),
        .meta_out (mmeta[0]), .y (my[0]), .b_out ()
    );

    ntc_mul_cell u_mul_d (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .meta_in (mmeta[0]), .a (ST_D_Q40), .b (my[0]), .c (ST_C_Q40),
        .meta_out (mmeta[1]), .y (my[1]), .b_out (mk[0])
    );

    ntc_mul_cell u_mul_c (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .meta_in (mmeta[1]), .a (my[1]), .b (mk[0]), .c (ST_B_Q40),
        .meta_out (mmeta[2]), .y (my[2]), .b_out (mk[1])
    );

    ntc_mul_cell u_mul_b (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .meta_in (mmeta[2]), .a (my[2]), .b (mk[1]), .c (ST_A_Q40),
        .meta_out (mmeta[3]), .y (my[3]), .b_out (mk[2])
    );

    logic [DEN_W-1:0]        den_mag;
    logic [NUM_W-1:0]        num;
    logic                    den_bad;
    meta_t                   pmeta_next, pmeta_reg;
    div_word_t               pw_reg;

    always_comb begin
        den_mag = my[3][DEN_W-1:0];
        num     = NUM_BASE + NUM_W'(den_mag >> 1);
        den_bad = my[3][MUL_W-1] || (my[3] == '0) || (mk[2] == '0 && 1'b0)
                || ((DEN_W+Q_BITS)'(num) >= {den_mag, {Q_BITS{1'b0}}});
        pmeta_next = mmeta[3];
        if (mmeta[3].status == ST_OK && den_bad) begin
            pmeta_next.status = ST_RANGE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pmeta_reg.valid <= 1'b0;
        end else if (en) begin
            pmeta_reg <= pmeta_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pw_reg.r   <= num;
            pw_reg.den <= den_mag;
            pw_reg.q   <= '0;
        end
    end

    meta_t     qmeta [Q_BITS+1];
    div_word_t qw [Q_BITS+1];

    assign qmeta[0] = pmeta_reg;
    assign qw[0]    = pw_reg;

    for (genvar j = 0; j < Q_BITS; j++) begin : g_div
        ntc_div_cell #(.SHIFT(Q_BITS - 1 - j)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .meta_in  (qmeta[j]),
            .w_in     (qw[j]),
            .meta_out (qmeta[j+1]),
            .w_out    (qw[j+1])
        );
    end

    logic signed [17:0] t_val, min_ext, max_ext;
    status_t            fin_status;
    logic               m_valid_reg;
    logic signed [14:0] m_temp_reg;
    status_t            m_status_reg;

    always_comb begin
        t_val   = $signed(18'(qw[Q_BITS].q)) - KELVIN_CENTI;
        min_ext = 18'(min_reg);
        max_ext = 18'(max_reg);
        fin_status = qmeta[Q_BITS].status;
        if (fin_status == ST_OK && (t_val < min_ext || t_val > max_ext)) begin
            fin_status = ST_RANGE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= qmeta[Q_BITS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_status_reg <= fin_status;
            m_temp_reg   <= (fin_status == ST_OK) ? t_val[14:0] : '0;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = m_status_reg;
    assign m_temperature_centi = m_temp_reg;

    `NTC_ASSERT_IMPLY(a_zero_unless_ok, aclk, aresetn,
        m_valid && m_status != ST_OK, m_temperature_centi == 15'sd0)
    `NTC_ASSERT_IMPLY(a_ok_within_limits, aclk, aresetn, m_valid && m_status == ST_OK,
        m_temperature_centi >= min_reg && m_temperature_centi <= max_reg)
    `NTC_ASSERT_NEXT(a_open_flagged, aclk, aresetn, s_valid && s_ready && v > open_thr_reg,
        meta0_reg.valid && meta0_reg.status == ST_OPEN)

endmodule

[bench/tb_ntc_thermistor_temperature_core.sv]
// Self-checking testbench for the NTC thermistor temperature conversion core.
module tb_ntc_thermistor_temperature_core;
    import ntc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] adc_value;
        logic [15:0] adc_top;
    } reading_t;

    typedef struct {
        logic signed [14:0] temp;
        status_t            status;
    } temp_result_t;

    localparam longint COEF_A = 64'sd3687780070;
    localparam longint COEF_B = 64'sd329997332;
    localparam longint COEF_C = 64'sd5591198;
    localparam longint COEF_D = 64'sd240535;
    localparam longint LN2_FX = 64'sd744261118;
    localparam longint LN_PULLUP = -64'sd4303580;
    localparam longint ZERO_C_CENTI = 64'sd27315;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 100;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [15:0]        s_adc_value;
    logic [15:0]        s_adc_top;
    logic               m_valid;
    logic               m_ready;
    logic signed [14:0] m_temperature_centi;
    logic [1:0]         m_status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    reading_t     pending_readings[$];
    temp_result_t expected_temps[$];

    logic [15:0]        open_limit;
    logic signed [14:0] min_centi;
    logic signed [14:0] max_centi;

    int  error_count;
    int  idle_cycles;
    bit  calm_phase;
    bit  hold_phase;
    int  hold_count;
    bit  timed_out;

    ntc_thermistor_temperature_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_adc_value(s_adc_value), .s_adc_top(s_adc_top),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_temperature_centi(m_temperature_centi), .m_status(m_status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint log2_fx(int unsigned n);
        int      ex;
        longint  m;
        longint  frac;
        ex = 0;
        frac = 0;
        for (int i = 15; i > 0; i--) begin
            if ((n >> i) != 0) begin
                ex = i;
                break;
            end
        end
        m = longint'(n) << (30 - ex);
        for (int i = 29; i >= 0; i--) begin
            m = (m * m) >>> 30;
            if (m >= (64'sd1 <<< 31)) begin
                m = m >>> 1;
                frac = frac | (64'sd1 <<< i);
            end
        end
        return (longint'(ex) <<< 30) + frac;
    endfunction

    function automatic longint mul_trunc(longint a, longint b);
        bit     neg;
        longint p;
        neg = (a < 0) != (b < 0);
        p = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >>> 30;
        return neg ? -p : p;
    endfunction

    function automatic temp_result_t convert_reading(reading_t r);
        temp_result_t    res;
        longint          diff;
        longint unsigned mag;
        longint          k;
        longint          den;
        longint          t;
        res.temp = '0;
        res.status = ST_OK;
        if (r.adc_value > open_limit) begin
            res.status = ST_OPEN;
        end else if (r.adc_value == 0 || r.adc_value >= r.adc_top) begin
            res.status = ST_RANGE;
        end else begin
            diff = log2_fx(r.adc_value) - log2_fx(r.adc_top - r.adc_value);
            mag = ($unsigned(diff < 0 ? -diff : diff) * $unsigned(LN2_FX)) >> 30;
            k = (diff < 0 ? -$signed(mag) : $signed(mag)) + LN_PULLUP;
            den = COEF_C + mul_trunc(COEF_D, k);
            den = COEF_B + mul_trunc(den, k);
            den = COEF_A + mul_trunc(den, k);
            if (den <= 0) begin
                res.status = ST_RANGE;
            end else begin
                t = ((64'sd100 <<< 40) + den / 2) / den - ZERO_C_CENTI;
                if (t < min_centi || t > max_centi) begin
                    res.status = ST_RANGE;
                end else begin
                    res.temp = t[14:0];
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic queue_reading(logic [15:0] v, logic [15:0] top);
        reading_t r;
        r.adc_value = v;
        r.adc_top = top;
        pending_readings.push_back(r);
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_OPEN: open_limit = data;
            CFG_MIN:  min_centi = data[14:0];
            CFG_MAX:  max_centi = data[14:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_readings.size() != 0 || expected_temps.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_random(int count);
        logic [15:0] top;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0: queue_reading(16'($urandom), 16'($urandom));
                1: queue_reading(16'($urandom_range(3)), 16'($urandom));
                2: begin
                    top = 16'($urandom);
                    queue_reading(top, top);
                end
                default: begin
                    top = 16'($urandom_range(65535, 20000));
                    queue_reading(16'($urandom_range(top - 1, 1)), top);
                end
            endcase
        end
    endtask

    // drive input transactions
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid && s_ready)
                void'(pending_readings.pop_front());
            if (pending_readings.size() > (s_valid && s_ready ? 0 : 0) &&
                (calm_phase || $urandom_range(99) >= 22)) begin
                s_valid <= 1'b1;
                s_adc_value <= pending_readings[0].adc_value;
                s_adc_top <= pending_readings[0].adc_top;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // predict on input acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            expected_temps.push_back(convert_reading('{s_adc_value, s_adc_top}));
    end

    // receive and check results
    always @(posedge aclk) begin
        temp_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_temps.size() == 0) begin
                    report_mismatch("unexpected result status", m_status, -1);
                end else begin
                    want = expected_temps.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_temperature_centi !== want.temp)
                        report_mismatch("temperature_centi", m_temperature_centi, want.temp);
                end
            end
            if (hold_phase && hold_count < 300) begin
                hold_count <= hold_count + 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm_phase || $urandom_range(99) >= 22;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready) || (pending_readings.size() == 0 &&
            expected_temps.size() == 0 && !cfg_valid)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        error_count = 0;
        idle_cycles = 0;
        calm_phase = 1'b0;
        hold_phase = 1'b0;
        aresetn = 1'b0;
        s_adc_value = '0;
        s_adc_top = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_OPEN;
        cfg_data = '0;
        open_limit = 16'd29800;
        min_centi = -15'sd4000;
        max_centi = 15'sd10500;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        queue_reading(16'd0, 16'd65535);
        queue_reading(16'd1, 16'd65535);
        queue_reading(16'd29800, 16'd65535);
        queue_reading(16'd29801, 16'd65535);
        queue_reading(16'd65535, 16'd65535);
        queue_reading(16'd20000, 16'd20000);
        queue_reading(16'd20000, 16'd10000);
        queue_reading(16'd16000, 16'd32768);
        queue_reading(16'd5000, 16'd32768);
        queue_reading(16'd100, 16'd65535);
        queue_reading(16'd29000, 16'd29001);
        queue_reading(16'd1000, 16'd0);
        queue_reading(16'd3, 16'd4);
        wait_drained();

        write_register(CFG_OPEN, 16'hFFFF);
        write_register(CFG_MIN, 16'(-5500));
        write_register(CFG_MAX, 16'd15000);
        queue_reading(16'd65534, 16'd65535);
        queue_reading(16'd65535, 16'd65535);
        queue_reading(16'd1, 16'd65535);
        queue_reading(16'd60000, 16'd61000);
        queue_random(500);
        hold_phase = 1'b1;
        wait_drained();
        hold_phase = 1'b0;

        write_register(CFG_OPEN, 16'd0);
        write_register(CFG_MIN, 16'd15000);
        write_register(CFG_MAX, 16'(-5500));
        queue_random(150);
        wait_drained();

        write_register(CFG_OPEN, 16'd40000);
        write_register(CFG_MIN, 16'd0);
        write_register(CFG_MAX, 16'd5000);
        calm_phase = 1'b1;
        queue_random(400);
        wait_drained();
        calm_phase = 1'b0;

        write_register(CFG_OPEN, 16'd29800);
        write_register(CFG_MIN, 16'(-4000));
        write_register(CFG_MAX, 16'd10500);
        queue_random(950);
        wait_drained();

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/ntc_pkg.sv
sv/ntc_log_cell.sv
sv/ntc_mul_cell.sv
sv/ntc_div_cell.sv
sv/ntc_thermistor_temperature_core.sv
bench/tb_ntc_thermistor_temperature_core.sv
